// ----- design/bitmap_id_allocator_core_assert.svh -----
// assertion macros shared by the allocator rtl
`ifndef BITMAP_ID_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_ID_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication, held off while in reset
`define BIA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// next-cycle implication, held off while in reset
`define BIA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

// ----- design/bia_pkg.sv -----
// ----------------------------------------------------------------------------
// bia_pkg
// shared constants and types of the bitmap identifier allocator
// ----------------------------------------------------------------------------
package bia_pkg;

    // map geometry
    localparam int ID_COUNT    = 4096;
    localparam int WORD_BITS   = 32;
    localparam int WORD_COUNT  = (ID_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int ID_W        = 12;
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int WORD_ADDR_W = $clog2(WORD_COUNT);

    // operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EXHAUSTED = 2'd1,
        STATUS_BAD_ID    = 2'd2
    } bia_status_t;

    typedef logic [WORD_BITS-1:0]   bia_word_t;
    typedef logic [BIT_W-1:0]       bia_bit_t;
    typedef logic [WORD_ADDR_W-1:0] bia_addr_t;

endpackage

// ----- design/bitmap_id_allocator_core.sv -----
// ----------------------------------------------------------------------------
// bitmap_id_allocator_core
// first-fit identifier allocator over a bitmap held in a word memory
// ----------------------------------------------------------------------------
//  channel  | signals                     | transfer
//  ---------+-----------------------------+-------------------------------
//  request  | start, operation, id_to_free| start high while busy low
//  result   | done, granted_id, status    | done high for one cycle
//
//  free of identifier zero: result in the cycle after the transfer, not busy.
//  free of any other identifier: one memory read, then one write.
//  allocate: words are scanned from word zero up to the first one with a
//  clear bit, at most 128 words; one memory word is read per cycle.
//  reset clears the per-word valid flags at once, so no clearing pass is run.
//  the receiver cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`include "bitmap_id_allocator_core_assert.svh"

module bitmap_id_allocator_core
    import bia_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  logic            operation,
    input  logic [ID_W-1:0] id_to_free,
    output logic            done,
    output logic [ID_W-1:0] granted_id,
    output logic [1:0]      status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FREE
    } state_t;

    localparam logic [ID_W:0] ID_LIMIT  = (ID_W + 1)'(ID_COUNT);
    localparam bia_addr_t     LAST_WORD = WORD_ADDR_W'(WORD_COUNT - 1);

    state_t      state_reg, state_next;
    bia_addr_t   chk_addr_reg, chk_addr_next;
    bia_bit_t    bit_sel_reg, bit_sel_next;
    logic        done_reg, done_next;
    logic [ID_W-1:0] granted_id_reg, granted_id_next;
    bia_status_t status_reg, status_next;

    // bitmap storage and per-word valid flags
    bia_word_t   bitmap_mem [WORD_COUNT];
    logic [WORD_COUNT-1:0] vld_reg;
    bia_word_t   rd_word_reg;
    logic        rd_vld_reg;
    bia_addr_t   rd_addr;
    logic        wr_en;
    bia_addr_t   wr_addr;
    bia_word_t   wr_data;

    bia_word_t   cur_word;
    logic        ffz_found;
    bia_bit_t    ffz_index;
    logic        accept;

    assign accept   = start && !busy;
    assign busy     = (state_reg != S_IDLE);
    assign cur_word = rd_vld_reg ? rd_word_reg : '0;

    // lowest clear bit of the word under test
    bia_ffz u_ffz (
        .word  (cur_word),
        .found (ffz_found),
        .index (ffz_index)
    );

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        chk_addr_next   = chk_addr_reg;
        bit_sel_next    = bit_sel_reg;
        done_next       = 1'b0;
        granted_id_next = '0;
        status_next     = STATUS_OK;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = chk_addr_reg;
        wr_data         = cur_word;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (operation == OP_ALLOC)
                    begin
                        rd_addr       = '0;
                        chk_addr_next = '0;
                        state_next    = S_SCAN;
                    end
                    else if (id_to_free == '0 || {1'b0, id_to_free} >= ID_LIMIT)
                    begin
                        done_next   = 1'b1;
                        status_next = STATUS_BAD_ID;
                    end
                    else
                    begin
                        rd_addr       = id_to_free[ID_W-1:BIT_W];
                        chk_addr_next = id_to_free[ID_W-1:BIT_W];
                        bit_sel_next  = id_to_free[BIT_W-1:0];
                        state_next    = S_FREE;
                    end
                end
            end
            S_SCAN:
            begin
                if (ffz_found)
                begin
                    wr_en           = 1'b1;
                    wr_data         = cur_word | (WORD_BITS'(1) << ffz_index);
                    done_next       = 1'b1;
                    granted_id_next = {chk_addr_reg, ffz_index};
                    status_next     = STATUS_OK;
                    state_next      = S_IDLE;
                end
                else if (chk_addr_reg == LAST_WORD)
                begin
                    done_next   = 1'b1;
                    status_next = STATUS_EXHAUSTED;
                    state_next  = S_IDLE;
                end
                else
                begin
                    rd_addr       = chk_addr_reg + 1'b1;
                    chk_addr_next = chk_addr_reg + 1'b1;
                end
            end
            S_FREE:
            begin
                wr_en       = 1'b1;
                wr_data     = cur_word & ~(WORD_BITS'(1) << bit_sel_reg);
                done_next   = 1'b1;
                status_next = STATUS_OK;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            chk_addr_reg   <= '0;
            bit_sel_reg    <= '0;
            done_reg       <= 1'b0;
            granted_id_reg <= '0;
            status_reg     <= STATUS_OK;
        end
        else
        begin
            state_reg      <= state_next;
            chk_addr_reg   <= chk_addr_next;
            bit_sel_reg    <= bit_sel_next;
            done_reg       <= done_next;
            granted_id_reg <= granted_id_next;
            status_reg     <= status_next;
        end
    end

    // valid flags, cleared at reset so unwritten words read as free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    // word memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bitmap_mem[wr_addr] <= wr_data;
        end
        rd_word_reg <= bitmap_mem[rd_addr];
        rd_vld_reg  <= vld_reg[rd_addr];
    end

    assign done       = done_reg;
    assign granted_id = granted_id_reg;
    assign status     = status_reg;

    // checks
    `BIA_ASSERT_NEXT(a_accept_progress, clk, rst_n, accept, busy || done)
    `BIA_ASSERT_IMPLY(a_fail_zero_id, clk, rst_n, done && status != STATUS_OK, granted_id == '0)
    `BIA_ASSERT_IMPLY(a_exhaust_last, clk, rst_n, done && status == STATUS_EXHAUSTED, $past(chk_addr_reg) == LAST_WORD)
    `BIA_ASSERT_IMPLY(a_no_done_scan, clk, rst_n, done, state_reg != S_FREE)

endmodule

// ----- design/bia_ffz.sv -----
// ----------------------------------------------------------------------------
// bia_ffz
// finds the lowest clear bit of one bitmap word
// ----------------------------------------------------------------------------
module bia_ffz
    import bia_pkg::*;
(
    input  bia_word_t word,
    output logic      found,
    output bia_bit_t  index
);

    // priority encode, scanning down so the lowest clear bit wins
    always_comb
    begin
        found = 1'b0;
        index = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!word[i])
            begin
                found = 1'b1;
                index = BIT_W'(i);
            end
        end
    end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the first-fit identifier allocator: a bitmap
// predictor in a scoreboard class works out each expected grant and status,
// and plain tasks drive directed transfers, random traffic and a release of
// every held identifier between the random phases
// ----------------------------------------------------------------------------
module tb_top
    import bia_pkg::*;
;

    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 200;

    // scoreboard with its own copy of the identifier map
    class alloc_scoreboard;
        typedef struct {
            logic [ID_W-1:0] granted;
            bia_status_t     st;
        } outcome_t;

        bia_word_t map_words[WORD_COUNT];
        outcome_t  awaited[$];
        int        errors;
        int        used_count;

        function new();
            foreach (map_words[i])
                map_words[i] = '0;
            errors     = 0;
            used_count = 0;
        endfunction

        function bit is_used(int id);
            return map_words[id / WORD_BITS][id % WORD_BITS];
        endfunction

        // predict the outcome of one accepted request and update the map
        function void note_request(logic op, logic [ID_W-1:0] id);
            outcome_t o;
            int       slot;
            slot      = -1;
            o.granted = '0;
            o.st      = STATUS_OK;
            if (op == OP_ALLOC)
            begin
                // lowest clear bit, searched word by word
                for (int w = 0; w < WORD_COUNT; w++)
                begin
                    if (slot < 0 && map_words[w] != '1)
                    begin
                        for (int b = 0; b < WORD_BITS; b++)
                        begin
                            if (slot < 0 && !map_words[w][b])
                                slot = w * WORD_BITS + b;
                        end
                    end
                end
                if (slot < 0)
                    o.st = STATUS_EXHAUSTED;
                else
                begin
                    map_words[slot / WORD_BITS][slot % WORD_BITS] = 1'b1;
                    used_count++;
                    o.granted = slot[ID_W-1:0];
                end
            end
            else if (id == '0 || int'(id) >= ID_COUNT)
                o.st = STATUS_BAD_ID;
            else
            begin
                // releasing an identifier that is already free is silent
                if (is_used(int'(id)))
                    used_count--;
                map_words[id / WORD_BITS][id % WORD_BITS] = 1'b0;
            end
            awaited.push_back(o);
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        // compare one result transfer with the oldest prediction
        task check_result(logic [ID_W-1:0] granted, logic [1:0] st);
            outcome_t o;
            if (awaited.size() == 0)
                report_mismatch($sformatf("unexpected result id %0d status %0d", granted, st));
            else
            begin
                o = awaited.pop_front();
                if (granted !== o.granted)
                    report_mismatch($sformatf("granted_id %0d, predicted %0d",
                                              granted, o.granted));
                if (st !== o.st)
                    report_mismatch($sformatf("status %0d, predicted %s", st, o.st.name()));
            end
        endtask
    endclass

    logic            clk        = 1'b0;
    logic            rst_n      = 1'b0;
    logic            start      = 1'b0;
    logic            operation  = OP_ALLOC;
    logic [ID_W-1:0] id_to_free = '0;
    logic            busy;
    logic            done;
    logic [ID_W-1:0] granted_id;
    logic [1:0]      status;

    alloc_scoreboard sb;
    int              quiet_cycles = 0;
    bit              idle_mode    = 1'b0;

    bitmap_id_allocator_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .id_to_free (id_to_free),
        .done       (done),
        .granted_id (granted_id),
        .status     (status)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // monitor: check results first, then note any new request transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(granted_id, status);
            if (start && !busy)
                sb.note_request(operation, id_to_free);
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // sender gap of a random length
    task automatic idle_burst();
        start <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
    endtask

    // present one request and hold it until the transfer; start stays high
    task automatic issue(logic op, logic [ID_W-1:0] id);
        if (idle_mode && $urandom_range(0, 3) == 0)
            idle_burst();
        start      <= 1'b1;
        operation  <= op;
        id_to_free <= id;
        do
            @(posedge clk);
        while (busy);
    endtask

    // sender holds off until every predicted result has arrived
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0)
            @(posedge clk);
    endtask

    // identifier likely to be in use, for well-formed frees
    function automatic logic [ID_W-1:0] pick_held_id();
        int hi;
        int id;
        hi = sb.used_count * 2 + 8;
        if (hi > ID_COUNT - 1)
            hi = ID_COUNT - 1;
        id = $urandom_range(1, hi);
        for (int k = 0; k < 8 && !sb.is_used(id); k++)
            id = $urandom_range(1, hi);
        return id[ID_W-1:0];
    endfunction

    // mostly allocates and frees of held identifiers, some zero and stray frees
    task automatic random_items(int count, bit calm);
        int pick;
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
                idle_mode = !calm && ($urandom_range(0, 2) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 55)
                issue(OP_ALLOC, ID_W'($urandom_range(0, ID_COUNT - 1)));
            else if (pick < 90)
                issue(OP_FREE, pick_held_id());
            else if (pick < 95)
                issue(OP_FREE, '0);
            else
                issue(OP_FREE, ID_W'($urandom_range(0, ID_COUNT - 1)));
        end
    endtask

    initial
    begin
        sb = new();

        // hold reset, then release it
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: first grants, bad and repeated frees, extremes of the field
        idle_mode = 1'b0;
        issue(OP_ALLOC, '0);
        issue(OP_ALLOC, '1);
        issue(OP_ALLOC, 12'hAAA);
        issue(OP_ALLOC, 12'h555);
        issue(OP_FREE, '0);
        issue(OP_FREE, 12'd2);
        issue(OP_FREE, 12'd2);
        issue(OP_ALLOC, '0);
        issue(OP_FREE, '1);
        issue(OP_FREE, 12'd1);
        issue(OP_ALLOC, '1);
        issue(OP_ALLOC, '0);
        issue(OP_FREE, 12'hAAA);
        issue(OP_FREE, 12'h555);
        issue(OP_FREE, 12'd3);
        issue(OP_FREE, '0);
        issue(OP_ALLOC, 12'h800);
        issue(OP_ALLOC, 12'h001);
        drain();

        // random traffic on top of the directed state
        random_items(250, 1'b0);

        // release every held identifier, leaving only identifier zero in use
        idle_mode = 1'b1;
        issue(OP_FREE, '0);
        for (int id = 1; id < ID_COUNT; id++)
        begin
            if (sb.is_used(id))
                issue(OP_FREE, id[ID_W-1:0]);
        end

        // random traffic from the released map, last stretch with no sender gaps
        random_items(150, 1'b0);
        random_items(100, 1'b1);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
